### hdl/bjp_pkg.sv
package bjp_pkg;

    localparam int BLOCK_DIM = 3;
    localparam int DIM_N     = (BLOCK_DIM == 2) ? 2 : 3;

    localparam int CW   = 65;
    localparam int PPW  = 65;
    localparam int PW   = 97;
    localparam int SW   = 99;
    localparam int NW   = SW + 16;
    localparam int DW   = SW;
    localparam int QW   = 32;
    localparam int CMPW = DW + QW;

    localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a02;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] a12;
        logic signed [31:0] a20;
        logic signed [31:0] a21;
        logic signed [31:0] a22;
        logic signed [31:0] r0;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] z0;
        logic signed [31:0] z1;
        logic signed [31:0] z2;
        logic               singular;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic          neg;
        logic          zero;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
    } t_lane_in;

    typedef struct packed {
        logic          neg;
        logic          zero;
        logic          ovf;
        logic [QW-1:0] q;
    } t_lane_out;

endpackage

### hdl/bjp_front.sv
module bjp_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic                     i_mode,
    input  bjp_pkg::t_in_item        i_item,
    output logic                     o_valid,
    output bjp_pkg::t_lane_in [2:0]  o_lane
);
    import bjp_pkg::*;

    logic [5:0]              r_vld;
    t_in_item                r_it [1:5];
    logic                    r_md [1:5];

    logic signed [63:0]      r_p1 [3][3];
    logic signed [63:0]      r_p2 [3][3];
    logic signed [CW-1:0]    r_c  [3][3];
    logic signed [PPW-1:0]   r_dlo [3];
    logic signed [PPW-1:0]   r_dhi [3];
    logic signed [PPW-1:0]   r_mlo [3][3];
    logic signed [PPW-1:0]   r_mhi [3][3];
    logic signed [PW-1:0]    r_df [3];
    logic signed [PW-1:0]    r_mf [3][3];
    logic signed [SW-1:0]    r_det;
    logic signed [SW-1:0]    r_num [3];
    t_lane_in [2:0]          r_lane;

    logic signed [31:0]      a0 [3][3];
    logic signed [31:0]      a1 [3][3];
    logic signed [31:0]      a2 [3][3];
    logic signed [31:0]      rv2 [3];
    logic signed [31:0]      a5 [3][3];
    logic signed [31:0]      rv5 [3];
    logic signed [63:0]      n_p1 [3][3];
    logic signed [63:0]      n_p2 [3][3];
    logic signed [CW-1:0]    n_c  [3][3];
    logic signed [PPW-1:0]   n_dlo [3];
    logic signed [PPW-1:0]   n_dhi [3];
    logic signed [PPW-1:0]   n_mlo [3][3];
    logic signed [PPW-1:0]   n_mhi [3][3];
    logic signed [PW-1:0]    n_df [3];
    logic signed [PW-1:0]    n_mf [3][3];
    logic signed [SW-1:0]    n_det;
    logic signed [SW-1:0]    n_num [3];
    t_lane_in [2:0]          n_lane;

    function automatic void unpack_item(input t_in_item it,
                                        output logic signed [31:0] m [3][3],
                                        output logic signed [31:0] v [3]);
        m[0][0] = it.a00; m[0][1] = it.a01; m[0][2] = it.a02;
        m[1][0] = it.a10; m[1][1] = it.a11; m[1][2] = it.a12;
        m[2][0] = it.a20; m[2][1] = it.a21; m[2][2] = it.a22;
        v[0] = it.r0; v[1] = it.r1; v[2] = it.r2;
    endfunction

    // cofactor products
    always_comb begin
        logic signed [31:0] vd [3];
        unpack_item(i_item, a0, vd);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p1[i][j] = a0[(i + 1) % 3][(j + 1) % 3] * a0[(i + 2) % 3][(j + 2) % 3];
                n_p2[i][j] = a0[(i + 1) % 3][(j + 2) % 3] * a0[(i + 2) % 3][(j + 1) % 3];
            end
        end
    end

    // cofactors
    always_comb begin
        logic signed [31:0] vd [3];
        unpack_item(r_it[1], a1, vd);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_c[i][j] = CW'(r_p1[i][j]) - CW'(r_p2[i][j]);
                if (DIM_N == 2) begin
                    n_c[i][j] = '0;
                end
            end
        end
        if (DIM_N == 2) begin
            n_c[0][0] = CW'(a1[1][1]);
            n_c[0][1] = -CW'(a1[1][0]);
            n_c[1][0] = -CW'(a1[0][1]);
            n_c[1][1] = CW'(a1[0][0]);
        end
    end

    // split products, low and high halves of each cofactor
    always_comb begin
        logic signed [32:0] lo;
        logic signed [32:0] hi;
        unpack_item(r_it[2], a2, rv2);
        for (int j = 0; j < 3; j++) begin
            lo = $signed({1'b0, r_c[0][j][31:0]});
            hi = r_c[0][j][CW-1:32];
            n_dlo[j] = lo * a2[0][j];
            n_dhi[j] = hi * a2[0][j];
        end
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                lo = $signed({1'b0, r_c[j][i][31:0]});
                hi = r_c[j][i][CW-1:32];
                n_mlo[j][i] = lo * rv2[j];
                n_mhi[j][i] = hi * rv2[j];
            end
        end
    end

    // full products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_df[j] = (PW'(r_dhi[j]) <<< 32) + PW'(r_dlo[j]);
            for (int i = 0; i < 3; i++) begin
                n_mf[j][i] = (PW'(r_mhi[j][i]) <<< 32) + PW'(r_mlo[j][i]);
            end
        end
    end

    // determinant and numerators
    always_comb begin
        n_det = SW'(r_df[0]) + SW'(r_df[1]) + SW'(r_df[2]);
        for (int i = 0; i < 3; i++) begin
            n_num[i] = SW'(r_mf[0][i]) + SW'(r_mf[1][i]) + SW'(r_mf[2][i]);
        end
    end

    // per lane dividend and divisor
    always_comb begin
        logic signed [SW-1:0] ns;
        logic signed [SW-1:0] ds;
        logic [SW-1:0]        na;
        logic [SW-1:0]        da;
        unpack_item(r_it[5], a5, rv5);
        for (int l = 0; l < 3; l++) begin
            if (!r_md[5]) begin
                ns = SW'(rv5[l]);
                ds = SW'(a5[l][l]);
            end else begin
                ns = r_num[l];
                ds = r_det;
            end
            if (l >= DIM_N) begin
                ns = '0;
                ds = SW'(1);
            end
            na = ns[SW-1] ? SW'(-ns) : SW'(ns);
            da = ds[SW-1] ? SW'(-ds) : SW'(ds);
            n_lane[l].neg  = ns[SW-1] ^ ds[SW-1];
            n_lane[l].zero = (ds == '0);
            n_lane[l].num  = NW'(na) << 16;
            n_lane[l].den  = da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[1] <= i_item;
            r_md[1] <= i_mode;
            for (int k = 2; k <= 5; k++) begin
                r_it[k] <= r_it[k - 1];
                r_md[k] <= r_md[k - 1];
            end
            r_p1   <= n_p1;
            r_p2   <= n_p2;
            r_c    <= n_c;
            r_dlo  <= n_dlo;
            r_dhi  <= n_dhi;
            r_mlo  <= n_mlo;
            r_mhi  <= n_mhi;
            r_df   <= n_df;
            r_mf   <= n_mf;
            r_det  <= n_det;
            r_num  <= n_num;
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_vld[5];
    assign o_lane  = r_lane;

endmodule

### hdl/bjp_lane.sv
module bjp_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bjp_pkg::t_lane_in   i_lane,
    output logic                o_valid,
    output bjp_pkg::t_lane_out  o_res
);
    import bjp_pkg::*;

    logic [QW:0]       r_v;
    logic [NW-1:0]     r_rem  [QW + 1];
    logic [DW-1:0]     r_den  [QW + 1];
    logic [QW-1:0]     r_q    [QW + 1];
    logic [QW:0]       r_neg;
    logic [QW:0]       r_zero;
    logic [QW:0]       r_ovf;

    logic [NW-1:0]     n_rem  [QW + 1];
    logic [QW-1:0]     n_q    [QW + 1];
    logic              n_ovf;

    // one quotient bit per stage, most significant first
    always_comb begin
        logic [CMPW-1:0] t;
        n_ovf    = {(CMPW - NW)'(0), i_lane.num} >= (CMPW'(i_lane.den) << QW);
        n_rem[0] = i_lane.num;
        n_q[0]   = '0;
        for (int j = 1; j <= QW; j++) begin
            t        = CMPW'(r_den[j - 1]) << (QW - j);
            n_rem[j] = r_rem[j - 1];
            n_q[j]   = r_q[j - 1];
            if (CMPW'(r_rem[j - 1]) >= t) begin
                n_rem[j]          = r_rem[j - 1] - t[NW-1:0];
                n_q[j][QW - j]    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem[0];
            r_q[0]    <= n_q[0];
            r_den[0]  <= i_lane.den;
            r_neg[0]  <= i_lane.neg;
            r_zero[0] <= i_lane.zero;
            r_ovf[0]  <= n_ovf;
            for (int j = 1; j <= QW; j++) begin
                r_rem[j]  <= n_rem[j];
                r_q[j]    <= n_q[j];
                r_den[j]  <= r_den[j - 1];
                r_neg[j]  <= r_neg[j - 1];
                r_zero[j] <= r_zero[j - 1];
                r_ovf[j]  <= r_ovf[j - 1];
            end
        end
    end

    assign o_valid    = r_v[QW];
    assign o_res.neg  = r_neg[QW];
    assign o_res.zero = r_zero[QW];
    assign o_res.ovf  = r_ovf[QW];
    assign o_res.q    = r_q[QW];

endmodule

### hdl/bjp_merge.sv
module bjp_merge (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  bjp_pkg::t_lane_out [2:0] i_res,
    output logic                     o_valid,
    output bjp_pkg::t_out_item       o_item
);
    import bjp_pkg::*;

    logic       r_valid;
    t_out_item  r_item;
    t_out_item  n_item;

    always_comb begin
        logic [QW-1:0] z [3];
        logic [2:0]    sat;
        logic          sing;
        for (int l = 0; l < 3; l++) begin
            sat[l] = 1'b0;
            if (i_res[l].neg) begin
                if (i_res[l].ovf || i_res[l].q > Q_MIN) begin
                    z[l]   = Q_MIN;
                    sat[l] = 1'b1;
                end else begin
                    z[l] = -i_res[l].q;
                end
            end else begin
                if (i_res[l].ovf || i_res[l].q > Q_MAX) begin
                    z[l]   = Q_MAX;
                    sat[l] = 1'b1;
                end else begin
                    z[l] = i_res[l].q;
                end
            end
        end
        sing = i_res[0].zero | i_res[1].zero | i_res[2].zero;
        n_item.singular  = sing;
        n_item.saturated = !sing && (|sat);
        n_item.z0        = sing ? '0 : $signed(z[0]);
        n_item.z1        = sing ? '0 : $signed(z[1]);
        n_item.z2        = sing ? '0 : $signed(z[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### hdl/block_jacobi_apply_3x3.sv
// 3x3 block Jacobi preconditioner, one node per item, signed Q16.16.
// Input channel i_in_valid / o_in_ready carries the node's 3x3 block and
// residual; output channel o_out_valid / i_out_ready carries z0..z2 with the
// singular and saturated flags. Configuration channel i_cfg_valid /
// o_cfg_ready writes the mode bit (0 diagonal, 1 full block inverse); write
// it only while the block is idle.
// The pipeline from input accept to output valid has 6 front stages
// (cofactor products, cofactors, split products, full products, sums, lane
// select), 33 stages in each of the three divider lanes (range check plus
// one quotient bit per stage) and the merge/output register.
// Throughput is one item per cycle unless the receiver stalls; the three
// restoring divider lanes run in parallel and the whole pipeline advances
// together. When the receiver stalls, the pipeline holds and o_in_ready
// drops until the waiting item is taken. Reset clears all valid bits and
// sets the mode to diagonal; it needs no clearing pass.
module block_jacobi_apply_3x3 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bjp_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bjp_pkg::t_out_item  o_out_item
);
    import bjp_pkg::*;

    logic                r_mode;
    logic                en;
    logic                front_valid;
    t_lane_in  [2:0]     lane_in;
    logic      [2:0]     lane_valid;
    t_lane_out [2:0]     lane_res;

    assign o_cfg_ready = 1'b1;
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    bjp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_mode  (r_mode),
        .i_item  (i_in_item),
        .o_valid (front_valid),
        .o_lane  (lane_in)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane
        bjp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (front_valid),
            .i_lane  (lane_in[l]),
            .o_valid (lane_valid[l]),
            .o_res   (lane_res[l])
        );
    end

    bjp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lane_valid[0]),
        .i_res   (lane_res),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.singular |->
            o_out_item.z0 == '0 && o_out_item.z1 == '0 && o_out_item.z2 == '0
            && !o_out_item.saturated)
        else $error("singular item with nonzero result");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saturated |->
            o_out_item.z0 == Q_MAX || o_out_item.z0 == Q_MIN ||
            o_out_item.z1 == Q_MAX || o_out_item.z1 == Q_MIN ||
            o_out_item.z2 == Q_MAX || o_out_item.z2 == Q_MIN)
        else $error("saturated flag without clamped component");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_valid[0] == lane_valid[1] && lane_valid[1] == lane_valid[2])
        else $error("divider lanes out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

### test/bjp_checker.sv
`timescale 1ns / 1ps

module bjp_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  bjp_pkg::t_in_item   i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  bjp_pkg::t_out_item  i_out_item,
    output int                  o_fail_count,
    output int                  o_pending
);
    import bjp_pkg::*;

    logic      jac_mode;
    t_out_item z_expected_q[$];
    int        fail_cnt;

    assign o_fail_count = fail_cnt;
    assign o_pending    = z_expected_q.size();

    // truncate toward zero, clamp to q16.16
    function automatic logic [31:0] fixed_quot(input logic signed [127:0] num,
                                               input logic signed [127:0] den,
                                               inout logic sat);
        logic signed [127:0] q;
        q = (num <<< 16) / den;
        if (q > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (q < -128'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return q[31:0];
    endfunction

    function automatic t_out_item precondition(input t_in_item it, input logic blk);
        logic signed [127:0] a [3][3];
        logic signed [127:0] r [3];
        logic signed [127:0] c [3][3];
        logic signed [127:0] det;
        logic signed [127:0] num;
        logic [31:0]         z [3];
        logic                sing;
        logic                sat;
        t_out_item           res;
        int                  n;
        n = (BLOCK_DIM == 2) ? 2 : 3;
        a[0][0] = it.a00; a[0][1] = it.a01; a[0][2] = it.a02;
        a[1][0] = it.a10; a[1][1] = it.a11; a[1][2] = it.a12;
        a[2][0] = it.a20; a[2][1] = it.a21; a[2][2] = it.a22;
        r[0] = it.r0; r[1] = it.r1; r[2] = it.r2;
        z[0] = '0; z[1] = '0; z[2] = '0;
        sing = 1'b0;
        sat = 1'b0;
        if (!blk) begin
            for (int i = 0; i < n; i++) if (a[i][i] == 0) sing = 1'b1;
            if (!sing) for (int i = 0; i < n; i++) z[i] = fixed_quot(r[i], a[i][i], sat);
        end else begin
            if (n == 2) begin
                c[0][0] = a[1][1]; c[0][1] = -a[1][0];
                c[1][0] = -a[0][1]; c[1][1] = a[0][0];
            end else begin
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        c[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                                - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
            end
            det = 0;
            for (int j = 0; j < n; j++) det += a[0][j] * c[0][j];
            if (det == 0) sing = 1'b1;
            else begin
                for (int i = 0; i < n; i++) begin
                    num = 0;
                    for (int j = 0; j < n; j++) num += c[j][i] * r[j];
                    z[i] = fixed_quot(num, det, sat);
                end
            end
        end
        if (sing) begin
            z[0] = '0; z[1] = '0; z[2] = '0;
            sat = 1'b0;
        end
        res.z0 = z[0]; res.z1 = z[1]; res.z2 = z[2];
        res.singular = sing;
        res.saturated = sat;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            jac_mode <= 1'b0;
            fail_cnt <= 0;
            z_expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) jac_mode <= i_cfg_data;
            if (i_in_valid && i_in_ready) z_expected_q.push_back(precondition(i_in_item, jac_mode));
            if (i_out_valid && i_out_ready) begin
                if (z_expected_q.size() == 0) begin
                    if (fail_cnt < 10) $display("unexpected item %h", i_out_item);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    want = z_expected_q.pop_front();
                    if (want !== i_out_item) begin
                        if (fail_cnt < 10)
                            $display("mismatch exp z=%h %h %h s=%b t=%b act z=%h %h %h s=%b t=%b",
                                want.z0, want.z1, want.z2, want.singular, want.saturated,
                                i_out_item.z0, i_out_item.z1, i_out_item.z2,
                                i_out_item.singular, i_out_item.saturated);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
        end
    end
endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import bjp_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic      cfg_data;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    bit        quiet;
    bit        hold_req;
    bit        hold_done;

    always begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    block_jacobi_apply_3x3 DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    bjp_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'h0001_0000 * $urandom_range(1, 8);
            4: return -(32'h0001_0000 * $urandom_range(1, 8));
            5: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item rand_node();
        t_in_item it;
        logic [31:0] w [12];
        for (int k = 0; k < 12; k++) w[k] = rand_word();
        it = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8], w[9], w[10], w[11]};
        case ($urandom_range(0, 5))
            0: begin
                it.a10 = it.a00; it.a11 = it.a01; it.a12 = it.a02;
            end
            1: it.a11 = 32'h0;
            2: begin
                it.a01 = 0; it.a02 = 0; it.a10 = 0; it.a12 = 0; it.a20 = 0; it.a21 = 0;
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in_item fill_node(input logic [31:0] v);
        return {12{v}};
    endfunction

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    task automatic send_node(input t_in_item it);
        idle_gap();
        in_item <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        cfg_data <= m;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_set();
        t_in_item it;
        send_node(fill_node(32'h7FFF_FFFF));
        send_node(fill_node(32'h8000_0000));
        send_node(fill_node(32'h0));
        send_node(fill_node(32'hFFFF_FFFF));
        it = '0;
        it.a00 = 32'h0001_0000; it.a11 = 32'h0002_0000; it.a22 = -32'sh0004_0000;
        it.r0 = 32'h0003_0000; it.r1 = 32'h8000_0000; it.r2 = 32'h7FFF_FFFF;
        send_node(it);
        it.a00 = 32'h1; it.r0 = 32'h7FFF_FFFF;
        send_node(it);
        it.a00 = -32'sh1; it.r0 = 32'h7FFF_FFFF;
        send_node(it);
        it.a11 = 32'h0;
        send_node(it);
    endtask

    // receiver side
    initial begin
        out_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (150) @(negedge clk);
                hold_done = 1'b1;
            end
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_set();
        write_mode(1'b1);
        directed_set();
        hold_req = 1'b1;
        for (int n = 0; n < 300; n++) send_node(rand_node());
        write_mode(1'b0);
        for (int n = 0; n < 300; n++) send_node(rand_node());
        write_mode(1'b1);
        for (int n = 0; n < 300; n++) send_node(rand_node());
        quiet = 1'b1;
        for (int n = 0; n < 200; n++) send_node(rand_node());
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule
